### hdl/vrd_pkg.sv
// ----------------------------------------------------------------------------
// vrd_pkg
// Shared types, layout tables and register indexes of the vertex record
// decompressor.
// ----------------------------------------------------------------------------
package vrd_pkg;

    localparam int NUM_LAY    = 10;
    localparam int POS_W      = 5;
    localparam int VIEW_BYTES = 32;
    localparam int CFG_IDX_W  = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TYPE   = 4'd0;
    localparam t_cfg_idx CFG_STRIDE = 4'd1;
    localparam t_cfg_idx CFG_MIN_X  = 4'd2;
    localparam t_cfg_idx CFG_MIN_Y  = 4'd3;
    localparam t_cfg_idx CFG_MIN_Z  = 4'd4;
    localparam t_cfg_idx CFG_MAX_X  = 4'd5;
    localparam t_cfg_idx CFG_MAX_Y  = 4'd6;
    localparam t_cfg_idx CFG_MAX_Z  = 4'd7;

    localparam logic [31:0] TYPE_CODE_RESET = 32'h0000d222;
    localparam logic [7:0]  STRIDE_RESET    = 8'd14;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_STRIDE = 2'd1,
        ST_TYPE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SK_NONE = 2'd0,
        SK_HARD = 2'd1,
        SK_SOFT = 2'd2
    } t_skin;

    localparam logic [31:0] LAY_CODE [NUM_LAY] = '{
        32'h0000d222, 32'h0000d322, 32'h0000d2a2, 32'h0000f226, 32'h0000f22e,
        32'h0000d262, 32'h0000d2e2, 32'h0000d362, 32'h0000f266, 32'h0000f26e
    };
    localparam logic [4:0] LAY_LEN [NUM_LAY] = '{
        5'd14, 5'd18, 5'd18, 5'd15, 5'd19, 5'd22, 5'd26, 5'd26, 5'd23, 5'd27
    };
    localparam t_skin LAY_SKIN [NUM_LAY] = '{
        SK_NONE, SK_NONE, SK_NONE, SK_HARD, SK_SOFT,
        SK_NONE, SK_NONE, SK_NONE, SK_HARD, SK_SOFT
    };
    localparam logic LAY_COL [NUM_LAY] = '{
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0
    };
    localparam logic [4:0] LAY_NRM_OFF [NUM_LAY] = '{
        5'd6, 5'd6, 5'd6, 5'd7, 5'd11, 5'd6, 5'd6, 5'd6, 5'd7, 5'd11
    };
    localparam logic [4:0] LAY_COL_OFF [NUM_LAY] = '{
        5'd0, 5'd10, 5'd10, 5'd0, 5'd0, 5'd0, 5'd18, 5'd18, 5'd0, 5'd0
    };
    localparam logic [4:0] LAY_TEX_OFF [NUM_LAY] = '{
        5'd10, 5'd14, 5'd14, 5'd11, 5'd15, 5'd18, 5'd22, 5'd22, 5'd19, 5'd23
    };

    typedef logic [2:0][31:0] t_box;

    typedef struct packed {
        logic [31:0] type_code;
        logic [7:0]  stride;
        logic        restart;
    } t_front_cfg;

    typedef struct packed {
        t_status          status;
        t_skin            skin;
        logic [2:0][15:0] pos_raw;
        logic [31:0]      nrm;
        logic [7:0]       wb0;
        logic [7:0]       wb1;
        logic [23:0]      idx;
        logic [31:0]      col;
        logic [31:0]      tex;
    } t_rec;

    typedef struct packed {
        t_status          status;
        logic [2:0][31:0] pos;
        logic [2:0][15:0] nrm;
        logic [23:0]      idx;
        logic [47:0]      wgt;
        logic [31:0]      col;
        logic [31:0]      tex;
        logic             pretransformed;
    } t_res;

endpackage

### hdl/vertex_record_decompressor.sv
// ----------------------------------------------------------------------------
// vertex_record_decompressor
// Decodes packed vertex buffer records, one little-endian byte per transfer,
// into one vertex result per record.
//
// Input channel (i_in_valid / o_in_ready) takes one byte per transfer. The
// configured type code and stride select the record layout; after the last
// byte of a record one decoded vertex leaves on the output channel
// (o_out_valid / i_out_ready). An unknown code or a wrong stride turns every
// byte into one error result.
// Throughput: one byte per cycle while the queue is not full. The
// position path (span multiply, divide by 65534 folding, clamp) sets the
// depth of the decode pipeline.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready; write
// only while the block is idle. Writing type code or stride restarts the
// record.
// Reset: registers return to their defaults and the record position clears.
// A stalled receiver holds the pipeline; a 4-entry queue then fills and
// o_in_ready drops.
// ----------------------------------------------------------------------------
module vertex_record_decompressor
    import vrd_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 27,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_position_x,
    output logic signed [31:0]   o_position_y,
    output logic signed [31:0]   o_position_z,
    output logic signed [15:0]   o_normal_x,
    output logic signed [15:0]   o_normal_y,
    output logic signed [15:0]   o_normal_z,
    output logic [23:0]          o_bone_indices,
    output logic [47:0]          o_bone_weights,
    output logic [31:0]          o_colour_word,
    output logic [31:0]          o_texcoords,
    output logic                 o_pretransformed
);

    logic [31:0] r_type_code;
    logic [7:0]  r_stride;
    t_box        r_box_min;
    t_box        r_box_max;
    logic        cfg_wr;
    t_front_cfg  front_cfg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_rec        q_in;
    t_rec        q_out;
    t_res        res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_code <= TYPE_CODE_RESET;
            r_stride    <= STRIDE_RESET;
            r_box_min   <= '0;
            r_box_max   <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_TYPE:   r_type_code  <= i_cfg_data;
                CFG_STRIDE: r_stride     <= i_cfg_data[7:0];
                CFG_MIN_X:  r_box_min[0] <= i_cfg_data;
                CFG_MIN_Y:  r_box_min[1] <= i_cfg_data;
                CFG_MIN_Z:  r_box_min[2] <= i_cfg_data;
                CFG_MAX_X:  r_box_max[0] <= i_cfg_data;
                CFG_MAX_Y:  r_box_max[1] <= i_cfg_data;
                CFG_MAX_Z:  r_box_max[2] <= i_cfg_data;
                default:    r_type_code  <= r_type_code;
            endcase
        end
    end

    assign front_cfg.type_code = r_type_code;
    assign front_cfg.stride    = r_stride;
    assign front_cfg.restart   = cfg_wr
                              && (i_cfg_index == CFG_TYPE || i_cfg_index == CFG_STRIDE);

    vrd_front #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (front_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_rec       (q_in)
    );

    vrd_queue #(
        .W     ($bits(t_rec)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_valid (q_valid)
    );

    vrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (q_out),
        .i_rec_valid (q_valid),
        .o_pop       (q_pop),
        .i_box_min   (r_box_min),
        .i_box_max   (r_box_max),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_status         = res.status;
    assign o_position_x     = res.pos[0];
    assign o_position_y     = res.pos[1];
    assign o_position_z     = res.pos[2];
    assign o_normal_x       = res.nrm[0];
    assign o_normal_y       = res.nrm[1];
    assign o_normal_z       = res.nrm[2];
    assign o_bone_indices   = res.idx;
    assign o_bone_weights   = res.wgt;
    assign o_colour_word    = res.col;
    assign o_texcoords      = res.tex;
    assign o_pretransformed = res.pretransformed;

endmodule

### hdl/vrd_queue.sv
// ----------------------------------------------------------------------------
// vrd_queue
// Small register FIFO between record assembly and the decode pipeline.
// ----------------------------------------------------------------------------
module vrd_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hdl/vrd_front.sv
// ----------------------------------------------------------------------------
// vrd_front
// Byte intake: classifies the configured layout, gathers record bytes and
// hands one record or error entry per result to the queue.
// ----------------------------------------------------------------------------
module vrd_front
    import vrd_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 27
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_front_cfg i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_rec       o_rec
);

    logic [POS_W-1:0]           r_pos;
    logic [7:0]                 r_bytes [MAX_RECORD_BYTES];
    logic [VIEW_BYTES-1:0][7:0] view;
    logic                       known;
    logic [3:0]                 lay;
    logic [4:0]                 len;
    logic                       stride_ok;
    logic                       acc;
    logic                       store;
    logic [POS_W-1:0]           pos_inc;
    logic                       last;

    function automatic logic [31:0] rd32(input logic [VIEW_BYTES-1:0][7:0] v,
                                         input logic [4:0] o);
        return {v[5'(o + 5'd3)], v[5'(o + 5'd2)], v[5'(o + 5'd1)], v[o]};
    endfunction

    always_comb begin
        known = 1'b0;
        lay   = '0;
        for (int k = 0; k < NUM_LAY; k++) begin
            if (i_cfg.type_code == LAY_CODE[k]) begin
                known = 1'b1;
                lay   = 4'(k);
            end
        end
    end

    assign len        = LAY_LEN[lay];
    assign stride_ok  = (i_cfg.stride == {3'b000, len});
    assign o_in_ready = !i_q_full;
    assign acc        = i_in_valid && o_in_ready;
    assign store      = acc && known && stride_ok;
    assign pos_inc    = r_pos + 1'b1;
    assign last       = (pos_inc >= len);
    assign o_push     = acc && (!known || !stride_ok || last);

    for (genvar i = 0; i < VIEW_BYTES; i++) begin : g_view
        if (i < MAX_RECORD_BYTES) begin : g_held
            assign view[i] = (store && r_pos == POS_W'(i)) ? i_data_byte : r_bytes[i];

            always_ff @(posedge i_clk) begin
                if (store && r_pos == POS_W'(i)) begin
                    r_bytes[i] <= i_data_byte;
                end
            end
        end else begin : g_absent
            assign view[i] = 8'd0;
        end
    end

    always_comb begin
        o_rec = '0;
        if (!known) begin
            o_rec.status = ST_TYPE;
        end else if (!stride_ok) begin
            o_rec.status = ST_STRIDE;
        end else begin
            o_rec.status = ST_OK;
            o_rec.skin   = LAY_SKIN[lay];
            for (int a = 0; a < 3; a++) begin
                o_rec.pos_raw[a] = {view[2*a+1], view[2*a]};
            end
            o_rec.nrm = rd32(view, LAY_NRM_OFF[lay]);
            case (LAY_SKIN[lay])
                SK_HARD: begin
                    o_rec.idx = {view[6], view[6], view[6]};
                end
                SK_SOFT: begin
                    o_rec.wb0 = view[6];
                    o_rec.wb1 = view[7];
                    o_rec.idx = {view[10], view[9], view[8]};
                end
                default: begin
                    o_rec.idx = '0;
                end
            endcase
            if (LAY_COL[lay]) begin
                o_rec.col = rd32(view, LAY_COL_OFF[lay]);
            end
            o_rec.tex = rd32(view, LAY_TEX_OFF[lay]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cfg.restart) begin
            r_pos <= '0;
        end else if (acc) begin
            r_pos <= (o_push) ? '0 : pos_inc;
        end
    end

endmodule

### hdl/vrd_back.sv
// ----------------------------------------------------------------------------
// vrd_back
// Decode pipeline: box interpolation, normal and weight scaling, output
// register.
// ----------------------------------------------------------------------------
module vrd_back
    import vrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_rec i_rec,
    input  logic i_rec_valid,
    output logic o_pop,
    input  t_box i_box_min,
    input  t_box i_box_max,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_res
);

    localparam int          NRM_K [3]    = '{10, 10, 9};
    localparam logic [25:0] NRM_BIAS [3] = '{26'd511, 26'd511, 26'd255};
    localparam int          WGT_K        = 8;
    localparam logic [25:0] WGT_BIAS     = 26'd127;
    localparam logic [15:0] WGT_ONE      = 16'd16384;

    logic        advance;
    logic [5:0]  r_vld;
    logic        r_out_valid;
    t_res        r_res;
    t_res        n_res;

    t_res        n1_c;
    logic [11:0] n1_nv [3];
    logic [7:0]  n1_wb [2];
    t_res        n3_c;

    t_res        r1_c, r2_c, r3_c, r4_c, r5_c, r6_c;
    t_skin       r1_skin, r2_skin;

    logic signed [32:0] r1_span [3];
    logic signed [17:0] r1_qv [3];
    logic [25:0]        r1_nx [3];
    logic               r1_nneg [3];
    logic [25:0]        r1_wx [2];

    logic signed [50:0] r2_prod [3];
    logic [25:0]        r2_nq [3];
    logic [25:0]        r2_ns [3];
    logic               r2_nneg [3];
    logic [25:0]        r2_wq [2];
    logic [25:0]        r2_ws [2];

    logic [47:0] r3_a [3];
    logic        r3_neg [3];
    logic [31:0] r4_q0 [3];
    logic [32:0] r4_s1 [3];
    logic        r4_neg [3];
    logic [32:0] r5_acc [3];
    logic [18:0] r5_s2 [3];
    logic        r5_neg [3];
    logic [32:0] r6_quot [3];
    logic        r6_neg [3];

    function automatic logic [25:0] fold(input logic [25:0] x, input int k);
        logic [25:0] mask;
        mask = (26'd1 << k) - 26'd1;
        return (x >> k) + (x & mask);
    endfunction

    function automatic logic [15:0] fold_quot(input logic [25:0] q0,
                                              input logic [25:0] s1, input int k);
        logic [25:0] mask;
        logic [25:0] s2;
        logic [25:0] q;
        mask = (26'd1 << k) - 26'd1;
        s2   = fold(s1, k);
        q    = q0 + (s1 >> k) + ((s2 >= mask) ? 26'd1 : 26'd0);
        return q[15:0];
    endfunction

    function automatic logic [25:0] nrm_seed(input logic [11:0] v, input logic [25:0] bias);
        logic [11:0] m;
        m = v[11] ? 12'(~v + 12'd1) : v;
        return {m, 14'd0} + bias;
    endfunction

    function automatic logic [15:0] sgn16(input logic [15:0] m, input logic neg);
        return neg ? 16'(~m + 16'd1) : m;
    endfunction

    function automatic logic [32:0] pos_tail(input logic [32:0] acc, input logic [18:0] s2);
        logic [15:0] s3;
        s3 = {1'b0, s2[14:0]} + {12'd0, s2[18:15]};
        return acc + {29'd0, s2[18:15]} + ((s3 >= 16'd32767) ? 33'd1 : 33'd0);
    endfunction

    assign advance     = !r_out_valid || i_out_ready;
    assign o_pop       = advance && i_rec_valid;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        n1_c                = '0;
        n1_c.status         = i_rec.status;
        n1_c.pos            = i_box_min;
        n1_c.idx            = i_rec.idx;
        n1_c.col            = i_rec.col;
        n1_c.tex            = i_rec.tex;
        n1_c.pretransformed = (i_rec.skin == SK_HARD);
        n1_nv[0]            = {i_rec.nrm[10], i_rec.nrm[10:0]};
        n1_nv[1]            = {i_rec.nrm[21], i_rec.nrm[21:11]};
        n1_nv[2]            = {{2{i_rec.nrm[31]}}, i_rec.nrm[31:22]};
        n1_wb[0]            = i_rec.wb0;
        n1_wb[1]            = i_rec.wb1;
    end

    always_comb begin
        logic [15:0] wx;
        logic [15:0] wy;
        n3_c = r2_c;
        for (int a = 0; a < 3; a++) begin
            n3_c.nrm[a] = sgn16(fold_quot(r2_nq[a], r2_ns[a], NRM_K[a]), r2_nneg[a]);
        end
        wx = fold_quot(r2_wq[0], r2_ws[0], WGT_K);
        wy = fold_quot(r2_wq[1], r2_ws[1], WGT_K);
        case (r2_skin)
            SK_SOFT: n3_c.wgt = {16'(WGT_ONE - wx - wy), wy, wx};
            SK_HARD: n3_c.wgt = {32'd0, WGT_ONE};
            default: n3_c.wgt = '0;
        endcase
    end

    always_comb begin
        logic signed [34:0] mn;
        logic signed [34:0] qq;
        logic signed [34:0] r;
        n_res = r6_c;
        for (int a = 0; a < 3; a++) begin
            mn = {{3{r6_c.pos[a][31]}}, r6_c.pos[a]};
            qq = {2'b00, r6_quot[a]};
            r  = r6_neg[a] ? mn - qq : mn + qq;
            if (r > 35'sd2147483647) begin
                n_res.pos[a] = 32'h7fffffff;
            end else if (r < -35'sd2147483648) begin
                n_res.pos[a] = 32'h80000000;
            end else begin
                n_res.pos[a] = r[31:0];
            end
            if (r6_c.status != ST_OK) begin
                n_res.pos[a] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_vld       <= {r_vld[4:0], i_rec_valid};
            r_out_valid <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_c    <= n1_c;
            r1_skin <= i_rec.skin;
            r2_c    <= r1_c;
            r2_skin <= r1_skin;
            r3_c    <= n3_c;
            r4_c    <= r3_c;
            r5_c    <= r4_c;
            r6_c    <= r5_c;
            r_res   <= n_res;
            for (int a = 0; a < 3; a++) begin
                r1_span[a] <= $signed({i_box_max[a][31], i_box_max[a]})
                            - $signed({i_box_min[a][31], i_box_min[a]});
                r1_qv[a]   <= $signed({{2{i_rec.pos_raw[a][15]}}, i_rec.pos_raw[a]})
                            + 18'sd32767;
                r1_nx[a]   <= nrm_seed(n1_nv[a], NRM_BIAS[a]);
                r1_nneg[a] <= n1_nv[a][11];

                r2_prod[a] <= r1_span[a] * r1_qv[a];
                r2_nq[a]   <= r1_nx[a] >> NRM_K[a];
                r2_ns[a]   <= fold(r1_nx[a], NRM_K[a]);
                r2_nneg[a] <= r1_nneg[a];

                r3_neg[a]  <= r2_prod[a][50];
                r3_a[a]    <= r2_prod[a][50] ? 48'(-r2_prod[a]) : r2_prod[a][47:0];

                r4_neg[a]  <= r3_neg[a];
                r4_q0[a]   <= r3_a[a][47:16];
                r4_s1[a]   <= {1'b0, r3_a[a][47:16]} + {18'd0, r3_a[a][15:1]};

                r5_neg[a]  <= r4_neg[a];
                r5_acc[a]  <= {1'b0, r4_q0[a]} + {15'd0, r4_s1[a][32:15]};
                r5_s2[a]   <= {1'b0, r4_s1[a][32:15]} + {4'd0, r4_s1[a][14:0]};

                r6_neg[a]  <= r5_neg[a];
                r6_quot[a] <= pos_tail(r5_acc[a], r5_s2[a]);
            end
            for (int b = 0; b < 2; b++) begin
                r1_wx[b] <= {4'd0, n1_wb[b], 14'd0} + WGT_BIAS;
                r2_wq[b] <= r1_wx[b] >> WGT_K;
                r2_ws[b] <= fold(r1_wx[b], WGT_K);
            end
        end
    end

endmodule
